// ===== src/sixteen_bit_instruction_decoder_core_assert.svh =====
// Assertion macros for the instruction decoder RTL.
`ifndef SIXTEEN_BIT_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define SIXTEEN_BIT_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SBID_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SBID_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

// ===== src/sbid_pkg.sv =====
// Package with opcode numbers, decode patterns and the result type of the decoder.
package sbid_pkg;

  localparam int unsigned WordW   = 16;
  localparam int unsigned OpcodeW = 5;

  // Dense opcode numbers.
  localparam logic [OpcodeW-1:0] OP_AR0 = 5'd0;
  localparam logic [OpcodeW-1:0] OP_JMP = 5'd1;
  localparam logic [OpcodeW-1:0] OP_SAR = 5'd2;
  localparam logic [OpcodeW-1:0] OP_R2C = 5'd6;
  localparam logic [OpcodeW-1:0] OP_NEG = 5'd10;
  localparam logic [OpcodeW-1:0] OP_SL4 = 5'd14;
  localparam logic [OpcodeW-1:0] OP_CPY = 5'd18;
  localparam logic [OpcodeW-1:0] OP_SHR = 5'd25;

  // Condition code that selects the immediate load form.
  localparam logic [2:0] COND_AR0 = 3'd7;

  // Bits 12, 11, 7 and 6 all set mark a jump.
  localparam logic [WordW-1:0] JMP_MASK = 16'h18C0;

  // Bits 12..6 patterns of the single-operand groups.
  localparam logic [6:0] GRP_SAR = 7'h06;
  localparam logic [6:0] GRP_R2C = 7'h16;
  localparam logic [6:0] GRP_NEG = 7'h0E;
  localparam logic [6:0] GRP_SL4 = 7'h1E;

  typedef struct packed {
    logic [OpcodeW-1:0] opcode;
    logic [2:0]         condition;
    logic [WordW-1:0]   ar0_value;
    logic               ar0_shift;
    logic signed [7:0]  jump_offset;
    logic [WordW-1:0]   jump_target;
    logic [3:0]         dest_reg;
    logic               dest_is_mem;
    logic [3:0]         src_reg;
    logic               src_is_mem;
  } result_t;

endpackage

// ===== src/sixteen_bit_instruction_decoder_core.sv =====
// Top level of the instruction decoder: input register, decode logic and result register.
//
// Use: the slave stream carries one instruction word and its word address per
// beat; the master stream returns one decoded result beat for every input beat,
// in order. There is no configuration.
// Path: an accepted beat is captured in the input register, decoded, then
// loaded into the result register, from which it leaves on the master stream.
// Throughput: one beat per cycle while tready is high. The decode between the
// two registers is a single pass of muxing and one 16-bit add for the jump target.
// Stalls: when the receiver holds tready low, the result register keeps its
// beat and the input register can still take one more beat; after that,
// s_axis_tready drops until the master side drains.
// Reset: both valid flags clear, so no beat is pending and both sides start
// empty; the block can take a beat as soon as reset is released.
module sixteen_bit_instruction_decoder_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // instr_word [15:0], instr_addr [31:16]
  input  logic [31:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // opcode [4:0], condition [7:5], ar0_value [23:8], ar0_shift [24],
  // jump_offset [32:25], jump_target [48:33], dest_reg [52:49],
  // dest_is_mem [53], src_reg [57:54], src_is_mem [58], zero [63:59]
  output logic [63:0] m_axis_tdata
);

  `include "sixteen_bit_instruction_decoder_core_assert.svh"

  logic                       in_valid_q;
  logic [sbid_pkg::WordW-1:0] word_q;
  logic [sbid_pkg::WordW-1:0] addr_q;
  logic                       out_valid_q;
  sbid_pkg::result_t          result_d;
  sbid_pkg::result_t          result_q;
  logic                       out_ready;

  // The result register can load when it is empty or its beat leaves now.
  assign out_ready     = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      word_q <= s_axis_tdata[15:0];
      addr_q <= s_axis_tdata[31:16];
    end
  end

  sbid_decode u_decode (
    .word_i   (word_q),
    .addr_i   (addr_q),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && in_valid_q) begin
      result_q <= result_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000,
                          result_q.src_is_mem,
                          result_q.src_reg,
                          result_q.dest_is_mem,
                          result_q.dest_reg,
                          result_q.jump_target,
                          result_q.jump_offset,
                          result_q.ar0_shift,
                          result_q.ar0_value,
                          result_q.condition,
                          result_q.opcode};

  // A new result only appears when the input register held a beat.
  `SBID_ASSERT_NOW(a_rise_from_input, $rose(out_valid_q), $past(in_valid_q))
  // Opcode numbers stop at the last ALU operation.
  `SBID_ASSERT_NOW(a_opcode_range, out_valid_q, result_q.opcode <= sbid_pkg::OP_SHR)
  // A jump never carries the immediate-load condition.
  `SBID_ASSERT_NOW(a_jump_cond, out_valid_q && result_q.opcode == sbid_pkg::OP_JMP,
                   result_q.condition != sbid_pkg::COND_AR0)
  // Immediate loads leave the jump and operand fields clear.
  `SBID_ASSERT_NOW(a_ar0_clear, out_valid_q && result_q.opcode == sbid_pkg::OP_AR0,
                   result_q.jump_target == 16'd0 && result_q.src_reg == 4'd0)
  // A full input register behind a stalled output keeps the slave side stalled.
  `SBID_ASSERT_NOW(a_backpressure, in_valid_q && out_valid_q && !m_axis_tready,
                   !s_axis_tready)

endmodule

// ===== src/sbid_decode.sv =====
// Combinational decode of one instruction word and its address into result fields.
module sbid_decode (
  input  logic [sbid_pkg::WordW-1:0] word_i,
  input  logic [sbid_pkg::WordW-1:0] addr_i,
  output sbid_pkg::result_t          result_o
);

  logic [6:0]                 group;
  logic [7:0]                 offset;
  logic [sbid_pkg::WordW-1:0] offset_ext;

  assign group      = word_i[12:6];
  assign offset     = {word_i[10], word_i[9], word_i[5:0]};
  assign offset_ext = {{8{offset[7]}}, offset};

  always_comb begin
    result_o           = '0;
    result_o.condition = word_i[15:13];
    if (word_i[15:13] == sbid_pkg::COND_AR0) begin
      result_o.opcode    = sbid_pkg::OP_AR0;
      result_o.ar0_shift = word_i[12];
      result_o.ar0_value = word_i[12] ? {word_i[11:0], 4'b0000} : {4'b0000, word_i[11:0]};
    end else if ((word_i & sbid_pkg::JMP_MASK) == sbid_pkg::JMP_MASK) begin
      result_o.opcode      = sbid_pkg::OP_JMP;
      result_o.jump_offset = offset;
      // The target wraps at 16 bits.
      result_o.jump_target = addr_i + 16'd1 + offset_ext;
    end else begin
      case (group)
        sbid_pkg::GRP_SAR: begin
          result_o.opcode  = sbid_pkg::OP_SAR + {3'b000, word_i[5:4]};
          result_o.src_reg = word_i[3:0];
        end
        sbid_pkg::GRP_R2C: begin
          result_o.opcode  = sbid_pkg::OP_R2C + {3'b000, word_i[5:4]};
          result_o.src_reg = word_i[3:0];
        end
        sbid_pkg::GRP_NEG: begin
          result_o.opcode  = sbid_pkg::OP_NEG + {3'b000, word_i[5:4]};
          result_o.src_reg = word_i[3:0];
        end
        sbid_pkg::GRP_SL4: begin
          result_o.opcode  = sbid_pkg::OP_SL4 + {3'b000, word_i[5:4]};
          result_o.src_reg = word_i[3:0];
        end
        default: begin
          result_o.opcode      = sbid_pkg::OP_CPY + {2'b00, word_i[12:10]};
          result_o.dest_is_mem = word_i[9];
          result_o.dest_reg    = word_i[8:5];
          result_o.src_is_mem  = word_i[4];
          result_o.src_reg     = word_i[3:0];
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_sixteen_bit_instruction_decoder_core.sv =====
// Self-checking testbench for the streaming 16-bit instruction decoder core.
`timescale 1ns / 1ps

module tb_sixteen_bit_instruction_decoder_core;

  localparam int unsigned RandomBeats = 700;
  localparam int unsigned QuietTail   = 100;
  localparam int unsigned HoldAtBeat  = 300;
  localparam int unsigned HoldCycles  = 40;
  localparam int unsigned StallLimit  = 2000;

  class decode_checker;
    sbid_pkg::result_t pending_decodes[$];
    int                mismatch_count = 0;

    function sbid_pkg::result_t decode_instruction(logic [15:0] w, logic [15:0] a);
      sbid_pkg::result_t            r;
      logic [7:0]                   off;
      logic [sbid_pkg::OpcodeW-1:0] base;
      bit                           special;
      r = '0;
      special = 1'b1;
      r.condition = w[15:13];
      if (w[15:13] == sbid_pkg::COND_AR0) begin
        r.opcode    = sbid_pkg::OP_AR0;
        r.ar0_shift = w[12];
        r.ar0_value = w[12] ? {w[11:0], 4'h0} : {4'h0, w[11:0]};
      end else if ((w & sbid_pkg::JMP_MASK) == sbid_pkg::JMP_MASK) begin
        off           = {w[10], w[9], w[5:0]};
        r.opcode      = sbid_pkg::OP_JMP;
        r.jump_offset = off;
        r.jump_target = a + 16'd1 + {{8{off[7]}}, off};
      end else begin
        case (w[12:6])
          sbid_pkg::GRP_SAR: base = sbid_pkg::OP_SAR;
          sbid_pkg::GRP_R2C: base = sbid_pkg::OP_R2C;
          sbid_pkg::GRP_NEG: base = sbid_pkg::OP_NEG;
          sbid_pkg::GRP_SL4: base = sbid_pkg::OP_SL4;
          default: begin
            base    = sbid_pkg::OP_CPY;
            special = 1'b0;
          end
        endcase
        if (special) begin
          r.opcode  = base + {3'b000, w[5:4]};
          r.src_reg = w[3:0];
        end else begin
          r.opcode      = sbid_pkg::OP_CPY + {2'b00, w[12:10]};
          r.dest_is_mem = w[9];
          r.dest_reg    = w[8:5];
          r.src_is_mem  = w[4];
          r.src_reg     = w[3:0];
        end
      end
      return r;
    endfunction

    task report(string what);
      $display("mismatch at %0t ns: %s", $time, what);
      mismatch_count++;
    endtask

    function void note_word(logic [15:0] w, logic [15:0] a);
      pending_decodes.push_back(decode_instruction(w, a));
    endfunction

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_beat(logic [63:0] beat);
      sbid_pkg::result_t want;
      if (pending_decodes.size() == 0) begin
        report("result beat with no instruction pending");
        return;
      end
      want = pending_decodes.pop_front();
      check_field("opcode", 16'(beat[4:0]), 16'(want.opcode));
      check_field("condition", 16'(beat[7:5]), 16'(want.condition));
      check_field("ar0_value", beat[23:8], want.ar0_value);
      check_field("ar0_shift", 16'(beat[24]), 16'(want.ar0_shift));
      check_field("jump_offset", 16'(beat[32:25]), 16'(unsigned'(want.jump_offset)));
      check_field("jump_target", beat[48:33], want.jump_target);
      check_field("dest_reg", 16'(beat[52:49]), 16'(want.dest_reg));
      check_field("dest_is_mem", 16'(beat[53]), 16'(want.dest_is_mem));
      check_field("src_reg", 16'(beat[57:54]), 16'(want.src_reg));
      check_field("src_is_mem", 16'(beat[58]), 16'(want.src_is_mem));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;

  decode_checker decode_sb = new();
  bit            quiet_tail;
  bit            hold_off_req;
  int unsigned   stall_cycles;

  sixteen_bit_instruction_decoder_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [15:0] group_word(logic [2:0] cond, logic [6:0] grp,
                                             logic [1:0] sub, logic [3:0] nib);
    return {cond, grp, sub, nib};
  endfunction

  function automatic logic [15:0] alu_word(logic [2:0] cond, logic [2:0] op, logic dmem,
                                           logic [3:0] dreg, logic smem, logic [3:0] sreg);
    return {cond, op, dmem, dreg, smem, sreg};
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [15:0] w, input logic [15:0] a);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {a, w};
    forever begin
      @(posedge clk_i);
      if (s_axis_tready) break;
    end
    decode_sb.note_word(w, a);
    @(negedge clk_i);
  endtask

  function automatic logic [15:0] random_addr();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] random_word();
    logic [15:0] w;
    logic [6:0]  grp;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    w = 16'($urandom);
    if (pick < 15) begin
      w[15:13] = sbid_pkg::COND_AR0;
    end else if (pick < 35) begin
      // Jump pattern under any condition but the immediate form.
      w = w | sbid_pkg::JMP_MASK;
      if (w[15:13] == sbid_pkg::COND_AR0) w[15:13] = 3'($urandom_range(0, 6));
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       grp = sbid_pkg::GRP_SAR;
        1:       grp = sbid_pkg::GRP_R2C;
        2:       grp = sbid_pkg::GRP_NEG;
        default: grp = sbid_pkg::GRP_SL4;
      endcase
      w = group_word(3'($urandom_range(0, 6)), grp, 2'($urandom), 4'($urandom));
    end
    return w;
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    bit          hold_done;
    hold_done     = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 4);
        m_axis_tready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) decode_sb.check_beat(m_axis_tdata);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet_tail    = 1'b0;
    hold_off_req  = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Immediate form: both shift settings, immediate at its extremes;
    // the all-ones word also carries the jump pattern, which must lose.
    send_beat(16'hE000, 16'h1234);
    send_beat(16'hEFFF, 16'h0000);
    send_beat(16'hF000, 16'hFFFF);
    send_beat(16'hFFFF, 16'h8000);
    // Jumps: largest forward, largest backward wrapping below zero,
    // and targets that wrap past the top of the address space.
    send_beat(16'h1AFF, 16'h7FF0);
    send_beat(16'hDCC0, 16'h0000);
    send_beat(16'h1EFF, 16'hFFFF);
    send_beat(16'h38C0, 16'hFFFF);
    // One beat per single-operand group, operand nibble at both extremes.
    send_beat(group_word(3'd0, sbid_pkg::GRP_SAR, 2'd0, 4'h0), 16'h0001);
    send_beat(group_word(3'd3, sbid_pkg::GRP_R2C, 2'd1, 4'hF), 16'h0002);
    send_beat(group_word(3'd5, sbid_pkg::GRP_NEG, 2'd2, 4'h0), 16'h0003);
    send_beat(group_word(3'd6, sbid_pkg::GRP_SL4, 2'd3, 4'hF), 16'h0004);
    // Every two-operand operation; register choices keep clear of the
    // jump and group patterns.
    for (int k = 0; k < 8; k++) begin
      send_beat(alu_word(3'(k % 7), 3'(k), k[0], 4'(15 - k), ~k[0], 4'(k * 2)),
                16'(k));
    end

    for (int n = 0; n < RandomBeats; n++) begin
      if (n == HoldAtBeat) hold_off_req = 1'b1;
      if (n == RandomBeats - QuietTail) quiet_tail = 1'b1;
      send_beat(random_word(), random_addr());
    end
    s_axis_tvalid <= 1'b0;

    while (decode_sb.pending_decodes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (decode_sb.mismatch_count == 0 && decode_sb.pending_decodes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
